// ===== sv/gll_pkg.sv =====
package gll_pkg;

  // Line length default (bytes counted per sentence is one less)
  localparam int LINE_LIMIT_DEFAULT = 100;

  // Characters of interest
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_W     = 8'h57;

  // Token numbers (non-empty tokens, counted from one)
  localparam logic [3:0] TOK_TYPE   = 4'd1;
  localparam logic [3:0] TOK_LAT    = 4'd2;
  localparam logic [3:0] TOK_NS     = 4'd3;
  localparam logic [3:0] TOK_LON    = 4'd4;
  localparam logic [3:0] TOK_EW     = 4'd5;
  localparam logic [3:0] TOK_STATUS = 4'd7;
  localparam logic [3:0] TOK_MAX    = 4'd8;

  localparam logic [2:0] TYPE_LEN   = 3'd6;
  localparam logic [2:0] FRAC_MAX   = 3'd4;
  localparam logic [1:0] INT_MIN    = 2'd2;

  // Raw digits of one coordinate token, captured when the token closes
  typedef struct packed {
    logic            ok;          // dot seen with at least two digits before it
    logic [4:0][3:0] bcd;         // last five integer digits, [0] is the newest
    logic [13:0]     frac;        // up to four fraction digits as a number
    logic [2:0]      frac_count;
  } coord_raw_t;

  // Per-sentence decisions
  typedef struct packed {
    logic update;                 // type matched and at least one token
    logic status_ok;
    logic south;
    logic west;
  } ctl_t;

  typedef struct packed {
    ctl_t       ctl;
    coord_raw_t lat;
    coord_raw_t lon;
  } snap_t;

  // Conversion results handed to the output stage
  typedef struct packed {
    logic [29:0] deg_e6;          // degrees times one million
    logic [20:0] q;               // minutes part, already scaled
  } coord_q_t;

  typedef struct packed {
    ctl_t     ctl;
    coord_q_t lat;
    coord_q_t lon;
  } fix_parts_t;

  // Expected text of the type token
  function automatic logic [7:0] type_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h24;  // $
      3'd1:    c = 8'h47;  // G
      3'd2:    c = 8'h4E;  // N
      3'd3:    c = 8'h47;  // G
      3'd4:    c = 8'h4C;  // L
      3'd5:    c = 8'h4C;  // L
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/gll_parse.sv =====
module gll_parse #(
  parameter int LINE_LIMIT = gll_pkg::LINE_LIMIT_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      ch,
  input  logic            eos,
  output logic            snap_valid,
  output gll_pkg::snap_t  snap,
  input  logic            snap_ready
);
  import gll_pkg::*;

  localparam int CountW = $clog2(LINE_LIMIT);
  localparam logic [CountW-1:0] LineMax = CountW'(LINE_LIMIT - 1);

  // Sentence state
  logic [CountW-1:0] byte_count, byte_count_next;
  logic [3:0]        token_index, token_index_next;
  logic              in_token, in_token_next;
  logic [2:0]        token_char_pos, token_char_pos_next;
  logic              type_match, type_match_next;
  logic [4:0][3:0]   bcd, bcd_next;
  logic [1:0]        int_count, int_count_next;
  logic [13:0]       frac, frac_next;
  logic [2:0]        frac_count, frac_count_next;
  logic              seen_dot, seen_dot_next;
  logic              frac_stop, frac_stop_next;
  coord_raw_t        lat_raw, lat_raw_next;
  coord_raw_t        lon_raw, lon_raw_next;
  logic              south, south_next;
  logic              west, west_next;
  logic              status_ok, status_ok_next;

  snap_t             snap_next;
  logic              take;
  logic              close;
  logic              is_digit;
  coord_raw_t        cur_raw;

  assign in_ready = !snap_valid || snap_ready;
  assign take     = in_valid && in_ready;
  assign is_digit = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);

  // Byte-by-byte token walk
  always_comb begin
    byte_count_next     = byte_count;
    token_index_next    = token_index;
    in_token_next       = in_token;
    token_char_pos_next = token_char_pos;
    type_match_next     = type_match;
    bcd_next            = bcd;
    int_count_next      = int_count;
    frac_next           = frac;
    frac_count_next     = frac_count;
    seen_dot_next       = seen_dot;
    frac_stop_next      = frac_stop;
    lat_raw_next        = lat_raw;
    lon_raw_next        = lon_raw;
    south_next          = south;
    west_next           = west;
    status_ok_next      = status_ok;
    close               = 1'b0;
    snap_next           = '0;
    cur_raw             = '0;

    if (take && (byte_count < LineMax)) begin
      if (ch == 8'h00) begin
        // zero byte ends the content
        byte_count_next = LineMax;
      end else begin
        byte_count_next = byte_count + 1'b1;
        if (ch == CHAR_COMMA) begin
          close = in_token;
        end else begin
          // open a new token
          if (!in_token) begin
            in_token_next = 1'b1;
            if (token_index < TOK_MAX) token_index_next = token_index + 1'b1;
            token_char_pos_next = '0;
            bcd_next            = '0;
            int_count_next      = '0;
            frac_next           = '0;
            frac_count_next     = '0;
            seen_dot_next       = 1'b0;
            frac_stop_next      = 1'b0;
          end
          case (token_index_next)
            TOK_TYPE: begin
              if (token_char_pos_next >= TYPE_LEN || ch != type_char(token_char_pos_next))
                type_match_next = 1'b0;
            end
            TOK_LAT, TOK_LON: begin
              if (!seen_dot_next) begin
                if (is_digit) begin
                  bcd_next = {bcd_next[3:0], ch[3:0]};
                  if (int_count_next < INT_MIN) int_count_next = int_count_next + 1'b1;
                end else if (ch == CHAR_DOT) begin
                  seen_dot_next = 1'b1;
                end else begin
                  bcd_next       = '0;
                  int_count_next = '0;
                end
              end else if (!frac_stop_next) begin
                if (!is_digit) begin
                  frac_stop_next = 1'b1;
                end else if (frac_count_next < FRAC_MAX) begin
                  frac_next       = 14'((frac_next << 3) + (frac_next << 1)) + 14'(ch[3:0]);
                  frac_count_next = frac_count_next + 1'b1;
                end
              end
            end
            TOK_NS: begin
              if (token_char_pos_next == '0) south_next = (ch == CHAR_S);
            end
            TOK_EW: begin
              if (token_char_pos_next == '0) west_next = (ch == CHAR_W);
            end
            TOK_STATUS: begin
              if (token_char_pos_next == '0) status_ok_next = (ch == CHAR_A);
            end
            default: ;
          endcase
          if (token_char_pos_next != '1) token_char_pos_next = token_char_pos_next + 1'b1;
        end
      end
    end

    // end of sentence closes an open token
    if (take && eos && in_token_next) close = 1'b1;

    cur_raw.ok         = seen_dot_next && (int_count_next == INT_MIN);
    cur_raw.bcd        = bcd_next;
    cur_raw.frac       = frac_next;
    cur_raw.frac_count = frac_count_next;

    if (close) begin
      if (token_index_next == TOK_TYPE && token_char_pos_next < TYPE_LEN)
        type_match_next = 1'b0;
      if (token_index_next == TOK_LAT) lat_raw_next = cur_raw;
      if (token_index_next == TOK_LON) lon_raw_next = cur_raw;
      in_token_next = 1'b0;
    end

    // snapshot the sentence and start afresh
    if (take && eos) begin
      snap_next.ctl.update    = type_match_next && (token_index_next != '0);
      snap_next.ctl.status_ok = status_ok_next;
      snap_next.ctl.south     = south_next;
      snap_next.ctl.west      = west_next;
      snap_next.lat           = lat_raw_next;
      snap_next.lon           = lon_raw_next;

      byte_count_next     = '0;
      token_index_next    = '0;
      in_token_next       = 1'b0;
      token_char_pos_next = '0;
      type_match_next     = 1'b1;
      bcd_next            = '0;
      int_count_next      = '0;
      frac_next           = '0;
      frac_count_next     = '0;
      seen_dot_next       = 1'b0;
      frac_stop_next      = 1'b0;
      lat_raw_next        = '0;
      lon_raw_next        = '0;
      south_next          = 1'b0;
      west_next           = 1'b0;
      status_ok_next      = 1'b0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count     <= '0;
      token_index    <= '0;
      in_token       <= 1'b0;
      token_char_pos <= '0;
      type_match     <= 1'b1;
      bcd            <= '0;
      int_count      <= '0;
      frac           <= '0;
      frac_count     <= '0;
      seen_dot       <= 1'b0;
      frac_stop      <= 1'b0;
      lat_raw        <= '0;
      lon_raw        <= '0;
      south          <= 1'b0;
      west           <= 1'b0;
      status_ok      <= 1'b0;
    end else begin
      byte_count     <= byte_count_next;
      token_index    <= token_index_next;
      in_token       <= in_token_next;
      token_char_pos <= token_char_pos_next;
      type_match     <= type_match_next;
      bcd            <= bcd_next;
      int_count      <= int_count_next;
      frac           <= frac_next;
      frac_count     <= frac_count_next;
      seen_dot       <= seen_dot_next;
      frac_stop      <= frac_stop_next;
      lat_raw        <= lat_raw_next;
      lon_raw        <= lon_raw_next;
      south          <= south_next;
      west           <= west_next;
      status_ok      <= status_ok_next;
    end
  end

  // Snapshot register towards the conversion
  always_ff @(posedge clk) begin
    if (rst) begin
      snap_valid <= 1'b0;
    end else if (in_ready) begin
      snap_valid <= take && eos;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && take && eos) begin
      snap <= snap_next;
    end
  end

endmodule

// ===== sv/gll_conv.sv =====
module gll_conv (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  gll_pkg::snap_t       in_snap,
  output logic                 out_valid,
  input  logic                 out_ready,
  output gll_pkg::fix_parts_t  out_fix
);
  import gll_pkg::*;

  localparam logic [29:0] Micro  = 30'd1000000;
  // ceil(2^25 / 3): exact quotient for dividends below 2^23
  localparam logic [23:0] Recip3 = 24'd11184811;

  typedef struct packed {
    logic [29:0] deg_e6;
    logic [22:0] m5;              // minutes value times five
  } coord_mid_t;

  typedef struct packed {
    ctl_t       ctl;
    coord_mid_t lat;
    coord_mid_t lon;
  } mid_t;

  function automatic logic [13:0] pow_ten(input logic [2:0] n);
    logic [13:0] p;
    case (n)
      3'd0:    p = 14'd1;
      3'd1:    p = 14'd10;
      3'd2:    p = 14'd100;
      3'd3:    p = 14'd1000;
      default: p = 14'd10000;
    endcase
    return p;
  endfunction

  // Degrees and minutes from the captured digits
  function automatic coord_mid_t mid_of(input coord_raw_t r);
    coord_mid_t m;
    logic [9:0]  deg;
    logic [6:0]  mm;
    logic [19:0] mins;
    deg  = 10'(r.bcd[4]) * 10'd100 + 10'(r.bcd[3]) * 10'd10 + 10'(r.bcd[2]);
    mm   = 7'(r.bcd[1]) * 7'd10 + 7'(r.bcd[0]);
    mins = 20'(mm) * 20'(pow_ten(r.frac_count)) + 20'(r.frac);
    m.deg_e6 = 30'(deg) * Micro;
    m.m5     = (23'(mins) << 2) + 23'(mins);
    if (!r.ok) m = '0;
    return m;
  endfunction

  // Divide by three through the reciprocal
  function automatic coord_q_t q_of(input coord_mid_t m);
    coord_q_t   c;
    logic [46:0] p;
    p        = 47'(m.m5) * 47'(Recip3);
    c.deg_e6 = m.deg_e6;
    c.q      = p[45:25];
    return c;
  endfunction

  mid_t mid;
  logic mid_valid;
  logic mid_ready;

  assign mid_ready = !out_valid || out_ready;
  assign in_ready  = !mid_valid || mid_ready;

  // Stage one: products by constants and by the power of ten
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
    end else if (in_ready) begin
      mid_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      mid.ctl <= in_snap.ctl;
      mid.lat <= mid_of(in_snap.lat);
      mid.lon <= mid_of(in_snap.lon);
    end
  end

  // Stage two: scaled minutes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (mid_ready) begin
      out_valid <= mid_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mid_ready && mid_valid) begin
      out_fix.ctl <= mid.ctl;
      out_fix.lat <= q_of(mid.lat);
      out_fix.lon <= q_of(mid.lon);
    end
  end

endmodule

// ===== sv/nmea_gll_position_parser.sv =====
// Channel   Dir  Transfer when          Contents
// s_*       in   s_tvalid & s_tready   tdata[7:0] ch, tlast end_of_sentence
// m_*       out  m_tvalid & m_tready   tdata accepted, fix_valid, latitude, longitude
//
// While s_tready is high, one byte is taken per cycle, back-to-back sentences too.
// The edge that takes the last byte of a sentence loads the snapshot register;
// two conversion stages and the output register follow, and m_tvalid rises
// when the output register loads the result.
// Reset clears the sentence state and the stored fix to zero; no clearing pass.
// With the output stalled, bytes keep flowing until all four result stages hold
// a sentence; only then does s_tready drop, for every byte.
module nmea_gll_position_parser #(
  parameter int LINE_LIMIT = gll_pkg::LINE_LIMIT_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] ch
  input  logic        s_tlast,   // end_of_sentence
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata    // [0] accepted, [1] fix_valid, [32:2] latitude,
                                 // [63:33] longitude
);
  import gll_pkg::*;

  snap_t        snap;
  logic         snap_valid;
  logic         snap_ready;
  fix_parts_t   fix;
  logic         fix_valid_in;
  logic         fix_ready;

  logic               accepted;
  logic               stored_valid;
  logic signed [30:0] stored_latitude;
  logic signed [30:0] stored_longitude;

  logic [29:0]        lat_mag;
  logic [29:0]        lon_mag;
  logic signed [30:0] lat_val;
  logic signed [30:0] lon_val;

  gll_parse #(
    .LINE_LIMIT (LINE_LIMIT)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .ch         (s_tdata),
    .eos        (s_tlast),
    .snap_valid (snap_valid),
    .snap       (snap),
    .snap_ready (snap_ready)
  );

  gll_conv u_conv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (snap_valid),
    .in_ready  (snap_ready),
    .in_snap   (snap),
    .out_valid (fix_valid_in),
    .out_ready (fix_ready),
    .out_fix   (fix)
  );

  // Final sums and signs
  assign lat_mag = fix.lat.deg_e6 + 30'(fix.lat.q);
  assign lon_mag = fix.lon.deg_e6 + 30'(fix.lon.q);
  assign lat_val = fix.ctl.south ? -$signed(31'(lat_mag)) : $signed(31'(lat_mag));
  assign lon_val = fix.ctl.west  ? -$signed(31'(lon_mag)) : $signed(31'(lon_mag));

  assign fix_ready = !m_tvalid || m_tready;

  // Output register and stored fix
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid         <= 1'b0;
      accepted         <= 1'b0;
      stored_valid     <= 1'b0;
      stored_latitude  <= '0;
      stored_longitude <= '0;
    end else if (fix_ready) begin
      m_tvalid <= fix_valid_in;
      if (fix_valid_in) begin
        accepted <= fix.ctl.update && fix.ctl.status_ok;
        if (fix.ctl.update) begin
          if (fix.ctl.status_ok) begin
            stored_latitude  <= lat_val;
            stored_longitude <= lon_val;
            stored_valid     <= 1'b1;
          end else begin
            stored_valid <= 1'b0;
          end
        end
      end
    end
  end

  assign m_tdata = {stored_longitude, stored_latitude, stored_valid, accepted};

endmodule
